>>> rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// widths, register indexes and reset values of the anti-windup pid controller
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int DATA_W     = 32;   // signed q16.16 data word
  localparam int LIM_W      = 31;   // unsigned limits and time step
  localparam int FRAC_W     = 16;   // fraction bits of q16.16
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DVD_W      = DATA_W + 1 + FRAC_W;  // |diff| scaled by 2^16
  localparam int CFG_ADDR_W = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_LIMIT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDUP_LIMIT = 3'd5;

  // register reset values
  localparam logic [DATA_W-1:0] PROP_GAIN_RST    = 32'h0001_0000;
  localparam logic [DATA_W-1:0] INTEG_GAIN_RST   = 32'h0000_0000;
  localparam logic [DATA_W-1:0] DERIV_GAIN_RST   = 32'h0000_0000;
  localparam logic [LIM_W-1:0]  TIME_STEP_RST    = 31'd655;
  localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST  = 31'h7FFF_FFFF;
  localparam logic [LIM_W-1:0]  WINDUP_LIMIT_RST = 31'h7FFF_FFFF;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

endpackage

>>> rtl/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// pid controller, derivative on measurement, integral clamp, bit-serial datapath
// ----------------------------------------------------------------------------
// One transaction on the input stream carries a setpoint and a measurement
// (signed q16.16) and yields exactly one drive value on the output stream.
// Items are handled one at a time. The pace is set by a single shared
// shift-and-add multiplier that retires one multiplier bit per cycle; it
// runs four passes (operand load, bit steps, sign restore, rescale and
// saturate) for the proportional term, the integral increment, the integral
// term and the derivative term. A restoring divider producing one quotient
// bit per cycle forms the derivative and runs alongside the first two
// multiplier passes, so it adds no time. The output register lets the next
// transaction be accepted while a drive value still waits for the sink.
// Gains, time step and limits are written through the plain write port;
// the user must do so only while the block is idle, as the block does not
// enforce it. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup
  import pidaw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*DATA_W-1:0]   in_tdata,    // [31:0] target, [63:32] measurement
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,   // [31:0] drive
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_MUL,
    S_NEG,
    S_SAT,
    S_INTEG,
    S_SUM,
    S_OUT
  } state_t;

  // which product the shared multiplier is working on
  typedef enum logic [1:0] {
    OP_P,
    OP_INC,
    OP_I,
    OP_D
  } op_t;

  // configuration registers
  logic signed [DATA_W-1:0] prop_gain_r;
  logic signed [DATA_W-1:0] integ_gain_r;
  logic signed [DATA_W-1:0] deriv_gain_r;
  logic        [LIM_W-1:0]  time_step_r;
  logic        [LIM_W-1:0]  drive_limit_r;
  logic        [LIM_W-1:0]  windup_limit_r;

  // controller state
  logic signed [DATA_W-1:0] integral_r;
  logic signed [DATA_W-1:0] last_meas_r;

  // sequencer and working registers
  state_t                   state_r;
  op_t                      op_r;
  logic signed [DATA_W-1:0] target_r;
  logic signed [DATA_W-1:0] meas_r;
  logic signed [DATA_W-1:0] error_r;
  logic signed [DATA_W-1:0] p_r;
  logic signed [DATA_W-1:0] inc_r;
  logic signed [DATA_W-1:0] i_r;
  logic signed [DATA_W-1:0] d_r;
  logic signed [DATA_W-1:0] total_r;

  // bit-serial multiplier
  logic [DATA_W-1:0]        mcand_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     mul_neg_r;
  logic [4:0]               mul_cnt_r;
  logic signed [PROD_W:0]   res_r;

  // restoring divider: dividend register shifts the quotient in from the bottom
  logic [DVD_W-1:0]         dvd_r;
  logic [LIM_W-1:0]         rem_r;
  logic [LIM_W-1:0]         dvs_r;
  logic                     div_neg_r;
  logic                     div_busy_r;
  logic [5:0]               div_cnt_r;

  // output register
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_data_r;

  // combinational helpers
  logic signed [DATA_W:0]   err_diff;
  logic signed [DATA_W-1:0] error_nxt;
  logic signed [DATA_W:0]   meas_diff;
  logic [DATA_W:0]          meas_mag;
  logic [LIM_W-1:0]         dvs_nxt;
  logic [DATA_W-1:0]        div_trial;
  logic                     div_ge;
  logic [LIM_W-1:0]         rem_nxt;
  logic [DATA_W-1:0]        deriv_mag;
  logic signed [DATA_W-1:0] opa;
  logic signed [DATA_W-1:0] opb;
  logic [DATA_W-1:0]        opa_mag;
  logic [DATA_W-1:0]        opb_mag;
  logic                     opb_neg;
  logic [DATA_W:0]          mul_sum;
  logic [PROD_W-1:0]        prod_nxt;
  logic signed [PROD_W:0]   res_nxt;
  logic signed [DVD_W-1:0]  scaled;
  logic signed [DATA_W-1:0] gm_nxt;
  logic signed [DATA_W:0]   integ_sum;
  logic signed [DATA_W:0]   windup_pos;
  logic signed [DATA_W:0]   windup_neg;
  logic signed [DATA_W-1:0] integral_nxt;
  logic signed [DATA_W+1:0] drive_sum;
  logic signed [DATA_W+1:0] drive_pos;
  logic signed [DATA_W+1:0] drive_neg;
  logic signed [DATA_W-1:0] total_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // error, saturated to 32 bits
  always_comb begin
    err_diff = {target_r[DATA_W-1], target_r} - {meas_r[DATA_W-1], meas_r};
    if (err_diff[DATA_W] != err_diff[DATA_W-1]) begin
      error_nxt = err_diff[DATA_W] ? S32_MIN : S32_MAX;
    end else begin
      error_nxt = err_diff[DATA_W-1:0];
    end
  end

  // derivative dividend in sign-magnitude, divisor of at least one lsb
  always_comb begin
    meas_diff = {last_meas_r[DATA_W-1], last_meas_r} - {meas_r[DATA_W-1], meas_r};
    meas_mag  = meas_diff[DATA_W] ? ((DATA_W+1)'(0) - meas_diff) : meas_diff;
    dvs_nxt   = (time_step_r == '0) ? LIM_W'(1) : time_step_r;
  end

  // one quotient bit per cycle
  always_comb begin
    div_trial = {rem_r, dvd_r[DVD_W-1]};
    div_ge    = (div_trial >= {1'b0, dvs_r});
    rem_nxt   = div_ge ? LIM_W'(div_trial - {1'b0, dvs_r}) : div_trial[LIM_W-1:0];
  end

  // derivative magnitude saturated to the 32-bit signed range
  always_comb begin
    if (div_neg_r) begin
      if ((dvd_r[DVD_W-1:DATA_W] != '0) ||
          (dvd_r[DATA_W-1] && (dvd_r[DATA_W-2:0] != '0))) begin
        deriv_mag = S32_MIN;
      end else begin
        deriv_mag = dvd_r[DATA_W-1:0];
      end
    end else begin
      if (dvd_r[DVD_W-1:DATA_W-1] != '0) begin
        deriv_mag = S32_MAX;
      end else begin
        deriv_mag = dvd_r[DATA_W-1:0];
      end
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (op_r)
      OP_P: begin
        opa = prop_gain_r;
        opb = error_r;
      end
      OP_INC: begin
        opa = error_r;
        opb = $signed({1'b0, time_step_r});
      end
      OP_I: begin
        opa = integ_gain_r;
        opb = integral_r;
      end
      OP_D: begin
        opa = deriv_gain_r;
        opb = '0;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    opa_mag = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
    if (op_r == OP_D) begin
      opb_mag = deriv_mag;
      opb_neg = div_neg_r;
    end else begin
      opb_mag = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;
      opb_neg = opb[DATA_W-1];
    end
  end

  // shift-and-add step, sign restore, floor rescale and saturation
  always_comb begin
    mul_sum  = {1'b0, prod_r[PROD_W-1:DATA_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_nxt = {mul_sum, prod_r[DATA_W-1:1]};
    res_nxt  = mul_neg_r ? ((PROD_W+1)'(0) - {1'b0, prod_r}) : {1'b0, prod_r};
    scaled   = res_r[PROD_W:FRAC_W];
    if (scaled[DVD_W-1:DATA_W-1] == {(DVD_W-DATA_W+1){scaled[DATA_W-1]}}) begin
      gm_nxt = scaled[DATA_W-1:0];
    end else begin
      gm_nxt = scaled[DVD_W-1] ? S32_MIN : S32_MAX;
    end
  end

  // integral clamp and output clamp
  always_comb begin
    integ_sum  = {integral_r[DATA_W-1], integral_r} + {inc_r[DATA_W-1], inc_r};
    windup_pos = $signed({2'b00, windup_limit_r});
    windup_neg = -windup_pos;
    if (integ_sum > windup_pos) begin
      integral_nxt = windup_pos[DATA_W-1:0];
    end else if (integ_sum < windup_neg) begin
      integral_nxt = windup_neg[DATA_W-1:0];
    end else begin
      integral_nxt = integ_sum[DATA_W-1:0];
    end

    drive_sum = (DATA_W+2)'(p_r) + (DATA_W+2)'(i_r) + (DATA_W+2)'(d_r);
    drive_pos = $signed({3'b000, drive_limit_r});
    drive_neg = -drive_pos;
    if (drive_sum > drive_pos) begin
      total_nxt = drive_pos[DATA_W-1:0];
    end else if (drive_sum < drive_neg) begin
      total_nxt = drive_neg[DATA_W-1:0];
    end else begin
      total_nxt = drive_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= PROP_GAIN_RST;
      integ_gain_r   <= INTEG_GAIN_RST;
      deriv_gain_r   <= DERIV_GAIN_RST;
      time_step_r    <= TIME_STEP_RST;
      drive_limit_r  <= DRIVE_LIMIT_RST;
      windup_limit_r <= WINDUP_LIMIT_RST;
      integral_r     <= '0;
      last_meas_r    <= '0;
      state_r        <= S_IDLE;
      op_r           <= OP_P;
      div_busy_r     <= 1'b0;
      div_cnt_r      <= '0;
      mul_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROP_GAIN:    prop_gain_r    <= cfg_wdata;
          REG_INTEG_GAIN:   integ_gain_r   <= cfg_wdata;
          REG_DERIV_GAIN:   deriv_gain_r   <= cfg_wdata;
          REG_TIME_STEP:    time_step_r    <= cfg_wdata[LIM_W-1:0];
          REG_DRIVE_LIMIT:  drive_limit_r  <= cfg_wdata[LIM_W-1:0];
          REG_WINDUP_LIMIT: windup_limit_r <= cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end

      // output register drains independently of the sequencer;
      // the hand-over state reloads it itself
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      // divider runs beside the multiplier
      if (div_busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DVD_W-2:0], div_ge};
        if (div_cnt_r == '0) begin
          div_busy_r <= 1'b0;
        end else begin
          div_cnt_r <= div_cnt_r - 6'd1;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            target_r <= in_tdata[DATA_W-1:0];
            meas_r   <= in_tdata[2*DATA_W-1:DATA_W];
            state_r  <= S_PREP;
          end
        end

        S_PREP: begin
          error_r     <= error_nxt;
          dvd_r       <= {meas_mag, {FRAC_W{1'b0}}};
          dvs_r       <= dvs_nxt;
          rem_r       <= '0;
          div_neg_r   <= meas_diff[DATA_W];
          div_cnt_r   <= 6'(DVD_W - 1);
          div_busy_r  <= 1'b1;
          last_meas_r <= meas_r;
          op_r        <= OP_P;
          state_r     <= S_LOAD;
        end

        S_LOAD: begin
          // derivative operand must wait for the divider
          if (!(op_r == OP_D && div_busy_r)) begin
            mcand_r   <= opa_mag;
            prod_r    <= {{DATA_W{1'b0}}, opb_mag};
            mul_neg_r <= opa[DATA_W-1] ^ opb_neg;
            mul_cnt_r <= 5'(DATA_W - 1);
            state_r   <= S_MUL;
          end
        end

        S_MUL: begin
          prod_r <= prod_nxt;
          if (mul_cnt_r == '0) begin
            state_r <= S_NEG;
          end else begin
            mul_cnt_r <= mul_cnt_r - 5'd1;
          end
        end

        S_NEG: begin
          res_r   <= res_nxt;
          state_r <= S_SAT;
        end

        S_SAT: begin
          case (op_r)
            OP_P: begin
              p_r     <= gm_nxt;
              op_r    <= OP_INC;
              state_r <= S_LOAD;
            end
            OP_INC: begin
              inc_r   <= gm_nxt;
              state_r <= S_INTEG;
            end
            OP_I: begin
              i_r     <= gm_nxt;
              op_r    <= OP_D;
              state_r <= S_LOAD;
            end
            OP_D: begin
              d_r     <= gm_nxt;
              state_r <= S_SUM;
            end
            default: state_r <= S_IDLE;
          endcase
        end

        S_INTEG: begin
          integral_r <= integral_nxt;
          op_r       <= OP_I;
          state_r    <= S_LOAD;
        end

        S_SUM: begin
          total_r <= total_nxt;
          state_r <= S_OUT;
        end

        S_OUT: begin
          // hand over once the output register is free or being emptied
          if (!out_valid_r || out_tready) begin
            out_data_r  <= total_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // integral stays inside the windup clamp after every update
  a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INTEG) |=>
      (integral_r <= $signed({1'b0, $past(windup_limit_r)})) &&
      (integral_r >= -$signed({1'b0, $past(windup_limit_r)})))
    else $error("integral outside windup clamp");

  // a result only appears out of the hand-over state
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside hand-over");

  // derivative product never starts before the quotient is complete
  a_div_before_d: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && op_r == OP_D && div_busy_r) |=> (state_r == S_LOAD))
    else $error("derivative product started with divider busy");

  // the multiplier is never running while a new item could be taken
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> !in_tready)
    else $error("input ready during multiply");

endmodule
